// ===== design/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types, constants and helpers for the IMU frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

    // Frame layout: twelve payload bytes, the first eleven are held in a store.
    localparam int PAYLOAD_BYTES = 12;
    localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;
    localparam int CNT_W         = $clog2(STORE_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LE_MODE      = CFG_IDX_W'(1);

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic       LE_MODE_RST      = 1'b1;

    typedef logic [7:0] t_byte;
    typedef t_byte      t_frame [PAYLOAD_BYTES];

    // One result item: six signed samples.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_imu_sample;

    // Status from the collector to the top level and the output stage.
    typedef struct packed {
        logic last_slot;   // next payload byte completes the frame
        logic frame_done;  // this cycle's transfer completed a frame
    } t_col_status;

    // Build one sample from two consecutive payload bytes.
    function automatic logic signed [15:0] pair_to_sample(input t_byte first,
                                                           input t_byte second,
                                                           input logic  le_mode);
        logic [15:0] v;
        begin
            v = le_mode ? {second, first} : {first, second};
            return $signed(v);
        end
    endfunction

endpackage

// ===== design/ifd_channels.sv =====
// ----------------------------------------------------------------------------
// ifd_channels
// Valid/ready channel interfaces for the byte input and the sample output.
// ----------------------------------------------------------------------------
interface imu_byte_if;
    import ifd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imu_sample_if;
    import ifd_pkg::*;
    logic        valid;
    logic        ready;
    t_imu_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/imu_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Byte-stream deframer for six-axis IMU frames.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle. While hunting it drops bytes until one
// equals the start marker; the next twelve bytes are payload, whatever their
// values, and the twelfth produces one result of six signed 16-bit samples
// (accel x/y/z, gyro x/y/z) in the byte order set by the little-endian bit.
// Each byte is handled as it arrives: the counter and payload store update on
// the transfer, and the completed frame goes straight into a one-deep result
// register, so a result appears the cycle after its last byte. Input stays
// ready every cycle except when the final payload byte is due and the result
// register holds a result that the sink is not taking in that same cycle.
// Configure only while idle.
// ----------------------------------------------------------------------------
module imu_frame_deframer
    import ifd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    imu_byte_if.sink              i_in,
    imu_sample_if.source          o_out
);

    t_byte       r_start_marker;
    logic        r_le_mode;
    t_col_status col_status;
    t_frame      frame;
    logic        can_load;
    logic        xfer;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_le_mode      <= LE_MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_MARKER: r_start_marker <= i_cfg_data[7:0];
                REG_LE_MODE:      r_le_mode      <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Only the frame-closing byte needs room in the result register.
    assign i_in.ready = !col_status.last_slot || can_load;
    assign xfer       = i_in.valid && i_in.ready;

    ifd_collector u_collector (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_xfer         (xfer),
        .i_byte         (i_in.data),
        .i_start_marker (r_start_marker),
        .o_status       (col_status),
        .o_frame        (frame)
    );

    ifd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (col_status.frame_done),
        .i_frame    (frame),
        .i_le_mode  (r_le_mode),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

// ===== design/ifd_collector.sv =====
// ----------------------------------------------------------------------------
// ifd_collector
// Marker hunt, payload byte counter and payload store.
// ----------------------------------------------------------------------------
module ifd_collector
    import ifd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_xfer,
    input  t_byte       i_byte,
    input  t_byte       i_start_marker,
    output t_col_status o_status,
    output t_frame      o_frame
);

    logic             r_hunting;
    logic [CNT_W-1:0] r_count;
    t_byte            r_store [STORE_DEPTH];

    logic             n_hunting;
    logic [CNT_W-1:0] n_count;
    logic             last_slot;

    assign last_slot = !r_hunting && (r_count == CNT_W'(STORE_DEPTH));

    // Next state of the hunt flag and the byte counter.
    always_comb begin
        n_hunting = r_hunting;
        n_count   = r_count;
        if (i_xfer) begin
            if (r_hunting) begin
                if (i_byte == i_start_marker) begin
                    n_hunting = 1'b0;
                    n_count   = '0;
                end
            end else if (last_slot) begin
                n_hunting = 1'b1;
                n_count   = '0;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_count   <= '0;
        end else begin
            r_hunting <= n_hunting;
            r_count   <= n_count;
        end
    end

    // Payload store: one byte written per transfer while collecting, except the frame-closing byte.
    always_ff @(posedge i_clk) begin
        if (i_xfer && !r_hunting && !last_slot) begin
            r_store[r_count] <= i_byte;
        end
    end

    // The full frame is the stored bytes plus the byte now arriving.
    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            o_frame[k] = r_store[k];
        end
        o_frame[STORE_DEPTH] = i_byte;
    end

    assign o_status.last_slot  = last_slot;
    assign o_status.frame_done = i_xfer && last_slot;

endmodule

// ===== design/ifd_out_stage.sv =====
// ----------------------------------------------------------------------------
// ifd_out_stage
// Sample assembly and the result register on the output channel.
// ----------------------------------------------------------------------------
module ifd_out_stage
    import ifd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_frame       i_frame,
    input  logic         i_le_mode,
    output logic         o_can_load,
    imu_sample_if.source o_out
);

    logic        r_valid;
    t_imu_sample r_data;
    t_imu_sample n_data;

    // The register can take a new result when empty or being drained.
    assign o_can_load = !r_valid || o_out.ready;

    // Pair up consecutive payload bytes in the configured byte order.
    always_comb begin
        n_data.accel_x = pair_to_sample(i_frame[0],  i_frame[1],  i_le_mode);
        n_data.accel_y = pair_to_sample(i_frame[2],  i_frame[3],  i_le_mode);
        n_data.accel_z = pair_to_sample(i_frame[4],  i_frame[5],  i_le_mode);
        n_data.gyro_x  = pair_to_sample(i_frame[6],  i_frame[7],  i_le_mode);
        n_data.gyro_y  = pair_to_sample(i_frame[8],  i_frame[9],  i_le_mode);
        n_data.gyro_z  = pair_to_sample(i_frame[10], i_frame[11], i_le_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

// ===== design/ifd_checker.sv =====
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks for the IMU frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ifd_checker
    import ifd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input t_imu_sample i_out_data
);

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its samples.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A new result only follows an input transfer.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without a closing input byte");

    // An empty or draining result register never blocks input.
    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with room for a result");

endmodule

bind imu_frame_deframer ifd_checker u_ifd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
